// ----- rtl/core/lgd_pkg.sv -----
// Shared types, constants and register codes for the line grid dark pixel counter.
package lgd_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int SPACING_FRAC_BITS  = 24;
    localparam int BAND_FRAC_BITS     = 16;
    localparam int COUNT_W            = 25;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 27;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0]         DARK_LIMIT = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 25'd16777216;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIN_ANGLE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COS_ANGLE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_OFFSET     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_SPACING = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_HALF_WIDTH = 3'd5;

    typedef struct packed {
        logic [12:0]        image_width;
        logic signed [15:0] sin_angle;
        logic signed [15:0] cos_angle;
        logic [26:0]        line_offset;
        logic [24:0]        inverse_spacing;
        logic [15:0]        band_half_width;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        image_width:     13'd4096,
        sin_angle:       16'sd0,
        cos_angle:       16'sd16384,
        line_offset:     27'd0,
        inverse_spacing: 25'd16777216,
        band_half_width: 16'd6554
    };

    typedef struct packed {
        logic [7:0] pixel_level;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic               on_line;
        logic [COUNT_W-1:0] dark_on_line_count;
        logic               frame_done;
    } result_t;

endpackage

// ----- rtl/core/lgd_front.sv -----
// Front end: raster position tracking, dark classification and the pixel queue.
module lgd_front #(
    parameter int COORD_BITS = lgd_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  lgd_pkg::pixel_t       pixel,
    input  logic [12:0]           image_width,
    output logic                  q_valid,
    input  logic                  q_pop,
    output logic [COORD_BITS-1:0] q_x,
    output logic [COORD_BITS-1:0] q_y,
    output logic                  q_dark,
    output logic                  q_last
);

    localparam int WW     = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int SPAN   = 1 << COORD_BITS;
    localparam int DEPTH  = lgd_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int ENTRY_W = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [WW-1:0]         eff_width;
    logic [WW-1:0]         col_plus;
    logic                  push;

    logic [ENTRY_W-1:0]    mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ENTRY_W-1:0]    rd_entry;
    logic                  pop;

    assign pixel_ready = (count_reg != CNT_W'(DEPTH));
    assign push        = pixel_valid && pixel_ready;
    assign q_valid     = (count_reg != '0);
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        if (image_width == 13'd0)
        begin
            eff_width = WW'(1);
        end
        else if (WW'(image_width) > WW'(SPAN))
        begin
            eff_width = WW'(SPAN);
        end
        else
        begin
            eff_width = WW'(image_width);
        end
        col_plus = WW'(col_reg) + WW'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (pixel.last_pixel)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_plus >= eff_width)
            begin
                col_next = '0;
                row_next = row_reg + COORD_BITS'(1);
            end
            else
            begin
                col_next = col_plus[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {pixel.pixel_level < lgd_pkg::DARK_LIMIT,
                                    pixel.last_pixel, col_reg, row_reg};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign rd_entry = mem_reg[rd_ptr_reg];
    assign q_dark   = rd_entry[ENTRY_W-1];
    assign q_last   = rd_entry[ENTRY_W-2];
    assign q_x      = rd_entry[2*COORD_BITS-1:COORD_BITS];
    assign q_y      = rd_entry[COORD_BITS-1:0];

endmodule

// ----- rtl/core/lgd_back.sv -----
// Back end: distance pipeline, band test, dark count and the result register.
module lgd_back #(
    parameter int COORD_BITS     = lgd_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = lgd_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lgd_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [COORD_BITS-1:0] q_x,
    input  logic [COORD_BITS-1:0] q_y,
    input  logic                  q_dark,
    input  logic                  q_last,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lgd_pkg::result_t      result
);

    localparam int FB      = TRIG_FRAC_BITS + lgd_pkg::SPACING_FRAC_BITS;
    localparam int PW      = COORD_BITS + 17;
    localparam int L       = FB / 2;
    localparam int H       = FB - L;
    localparam int STAGES  = 5;
    localparam int CW      = lgd_pkg::COUNT_W;
    localparam logic [FB-1:0] HALF = {1'b1, {(FB-1){1'b0}}};

    logic                  adv;
    logic [STAGES-1:0]     valid_reg;
    logic [STAGES-1:0]     dark_reg;
    logic [STAGES-1:0]     last_reg;

    logic signed [PW-1:0]  ycos_next, xsin_next;
    logic signed [PW-1:0]  ycos_reg, xsin_reg;
    logic [FB-1:0]         d_next, d_reg;
    logic [FB-1:0]         p1_next, p1_reg;
    logic [H-1:0]          p2_next, p2_reg;
    logic [FB-1:0]         pos_next, pos_reg;
    logic [FB-1:0]         dist_next, dist_reg;
    logic [FB-1:0]         band_scaled;
    logic                  on;
    logic                  inc;
    logic [CW-1:0]         count_reg, count_next, count_sum;

    logic                  res_valid_reg;
    lgd_pkg::result_t      res_reg;

    assign adv   = !res_valid_reg || result_ready;
    assign q_pop = adv && q_valid;

    assign ycos_next = $signed({1'b0, q_y}) * cfg.cos_angle;
    assign xsin_next = $signed({1'b0, q_x}) * cfg.sin_angle;
    assign d_next    = {{(FB-PW){ycos_reg[PW-1]}}, ycos_reg}
                     - {{(FB-PW){xsin_reg[PW-1]}}, xsin_reg}
                     - FB'(cfg.line_offset);
    assign p1_next   = FB'(d_reg[L-1:0]) * FB'(cfg.inverse_spacing);
    assign p2_next   = H'(d_reg[FB-1:L]) * H'(cfg.inverse_spacing[H-1:0]);
    assign pos_next  = p1_reg + {p2_reg, {L{1'b0}}};
    assign dist_next = (pos_reg <= HALF) ? pos_reg : (~pos_reg + FB'(1));

    assign band_scaled = {cfg.band_half_width, {(FB-lgd_pkg::BAND_FRAC_BITS){1'b0}}};
    assign on          = dist_reg < band_scaled;
    assign inc         = on && dark_reg[STAGES-1] && (count_reg < lgd_pkg::COUNT_MAX);
    assign count_sum   = count_reg + CW'(inc);
    assign count_next  = last_reg[STAGES-1] ? '0 : count_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[STAGES-2:0], q_valid};
            res_valid_reg <= valid_reg[STAGES-1];
            if (valid_reg[STAGES-1])
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dark_reg <= {dark_reg[STAGES-2:0], q_dark};
            last_reg <= {last_reg[STAGES-2:0], q_last};
            ycos_reg <= ycos_next;
            xsin_reg <= xsin_next;
            d_reg    <= d_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            pos_reg  <= pos_next;
            dist_reg <= dist_next;
            res_reg.on_line            <= on;
            res_reg.dark_on_line_count <= count_sum;
            res_reg.frame_done         <= last_reg[STAGES-1];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/core/line_grid_dark_pixel_counter.sv -----
// Top level: configuration registers, front end and back end of the dark pixel counter.
// Path: an accepted pixel beat passes the queue, the back pipeline and the result register.
// Throughput: one pixel per cycle sustained; a stalled result freezes the back pipeline
// while the 4-entry queue keeps taking pixels until it fills.
// Reset: clears row and column position, dark count and queue; registers take defaults.
// No clearing pass after reset; the config port is always ready.
module line_grid_dark_pixel_counter #(
    parameter int COORD_BITS     = lgd_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = lgd_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  lgd_pkg::pixel_t                  pixel,
    output logic                             result_valid,
    input  logic                             result_ready,
    output lgd_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lgd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lgd_pkg::cfg_t         cfg_reg, cfg_next;
    logic                  q_valid;
    logic                  q_pop;
    logic [COORD_BITS-1:0] q_x;
    logic [COORD_BITS-1:0] q_y;
    logic                  q_dark;
    logic                  q_last;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lgd_pkg::CFG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[12:0];
                lgd_pkg::CFG_SIN_ANGLE:       cfg_next.sin_angle       = cfg_data[15:0];
                lgd_pkg::CFG_COS_ANGLE:       cfg_next.cos_angle       = cfg_data[15:0];
                lgd_pkg::CFG_LINE_OFFSET:     cfg_next.line_offset     = cfg_data[26:0];
                lgd_pkg::CFG_INVERSE_SPACING: cfg_next.inverse_spacing = cfg_data[24:0];
                lgd_pkg::CFG_BAND_HALF_WIDTH: cfg_next.band_half_width = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lgd_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lgd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .image_width (cfg_reg.image_width),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_x         (q_x),
        .q_y         (q_y),
        .q_dark      (q_dark),
        .q_last      (q_last)
    );

    lgd_back #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_dark       (q_dark),
        .q_last       (q_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
